// File: rtl/core/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants of the lru cache simulator
// field widths, operation and outcome codes, configuration and control structs
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int OP_W      = 2;
    localparam int ADDR_W    = 64;
    localparam int TAG_W     = 64;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int OUTC_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;
    localparam int SBITS_W   = 4;
    localparam int WAYS_W    = 4;
    localparam int OFFS_W    = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OP_W-1:0] OP_IFETCH = 2'd3;

    // outcome codes
    localparam logic [OUTC_W-1:0] OUT_NONE  = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_HIT   = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_MISS  = 2'd2;
    localparam logic [OUTC_W-1:0] OUT_EVICT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

    // configuration reset values
    localparam logic [SBITS_W-1:0] ROW_BITS_RST    = 4'd4;
    localparam logic [WAYS_W-1:0]  WAYS_RST        = 4'd1;
    localparam logic [OFFS_W-1:0]  OFFSET_BITS_RST = 6'd4;

    typedef struct packed {
        logic [SBITS_W-1:0] row_bits;
        logic [WAYS_W-1:0]  ways;
        logic [OFFS_W-1:0]  offset_bits;
    } t_cfg;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_sts;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } t_state;

endpackage

// File: rtl/core/salc_req_if.sv
// ----------------------------------------------------------------------------
// salc_req_if: access request channel
// valid/ready handshake carrying one memory access
// ----------------------------------------------------------------------------
interface salc_req_if;
    logic                         valid;
    logic                         ready;
    logic [salc_pkg::OP_W-1:0]    operation;
    logic [salc_pkg::ADDR_W-1:0]  address;

    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

// File: rtl/core/salc_rsp_if.sv
// ----------------------------------------------------------------------------
// salc_rsp_if: access result channel
// valid/ready handshake carrying outcome and running totals
// ----------------------------------------------------------------------------
interface salc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [salc_pkg::OUTC_W-1:0]   outcome;
    logic                          extra_hit;
    logic [salc_pkg::CNT_W-1:0]    hit_total;
    logic [salc_pkg::CNT_W-1:0]    miss_total;
    logic [salc_pkg::CNT_W-1:0]    eviction_total;

    modport source (output valid, output outcome, output extra_hit, output hit_total,
                    output miss_total, output eviction_total, input ready);
    modport sink   (input valid, input outcome, input extra_hit, input hit_total,
                    input miss_total, input eviction_total, output ready);
endinterface

// File: rtl/core/set_assoc_lru_cache_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim: set-associative cache simulator, lru replacement
// counts hits, misses and evictions of a stream of memory accesses
// ----------------------------------------------------------------------------
// Each request item is one access (load, store, modify or instruction fetch)
// with a 64-bit byte address; each yields one result item with the outcome,
// the modify extra-hit flag and the saturating running totals. A set's ways
// (valid, tag, last-use stamp) live in one row of a memory of MAX_SETS rows,
// so the accept cycle reads the set row and the lookup state compares all
// ways side by side, picks the hit, lowest empty or least stamp way and, but
// for an instruction fetch, writes the row back. That read-then-write of the
// single row memory lets a new item in only once the last has left lookup.
// The result sits in an output register; a new item is still taken while it
// waits, and its lookup holds until the result is taken. After reset, a clearing
// pass over all MAX_SETS rows zeroes the valid bits, taking no item; config
// writes are taken at any time and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [salc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [salc_pkg::CFG_DAT_W-1:0]      i_cfg_wdata,
    // item channels
    salc_req_if.sink                            i_req,
    salc_rsp_if.source                          o_rsp
);

    // configuration registers
    salc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_bits    <= salc_pkg::ROW_BITS_RST;
            r_cfg.ways        <= salc_pkg::WAYS_RST;
            r_cfg.offset_bits <= salc_pkg::OFFSET_BITS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                salc_pkg::CFG_ROW_BITS: begin
                    r_cfg.row_bits <= i_cfg_wdata[salc_pkg::SBITS_W-1:0];
                end
                salc_pkg::CFG_WAYS: begin
                    r_cfg.ways <= i_cfg_wdata[salc_pkg::WAYS_W-1:0];
                end
                salc_pkg::CFG_OFFSET_BITS: begin
                    r_cfg.offset_bits <= i_cfg_wdata[salc_pkg::OFFS_W-1:0];
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // controller <-> datapath
    salc_pkg::t_cmd w_cmd;
    salc_pkg::t_sts w_sts;

    salc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    salc_dp #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_operation      (i_req.operation),
        .i_address        (i_req.address),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_outcome        (o_rsp.outcome),
        .o_extra_hit      (o_rsp.extra_hit),
        .o_hit_total      (o_rsp.hit_total),
        .o_miss_total     (o_rsp.miss_total),
        .o_eviction_total (o_rsp.eviction_total)
    );

    // clear, accept and update never overlap
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clear_wr, w_cmd.accept, w_cmd.update}))
        else $error("controller issued overlapping commands");

    // one item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while lookup pending");

    // an update always leaves a result waiting
    a_update_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.update |=> o_rsp.valid)
        else $error("update did not produce a result");

    // an ignored access cannot carry the modify extra hit
    a_fetch_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.outcome == salc_pkg::OUT_NONE)) |-> !o_rsp.extra_hit)
        else $error("extra hit on an ignored access");

endmodule

// File: rtl/core/salc_ram.sv
// ----------------------------------------------------------------------------
// salc_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/salc_ctrl.sv
// ----------------------------------------------------------------------------
// salc_ctrl: sequencing state machine
// clearing pass after reset, then accept / lookup-and-update per item
// ----------------------------------------------------------------------------
module salc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  salc_pkg::t_sts  i_sts,
    output salc_pkg::t_cmd  o_cmd
);

    salc_pkg::t_state r_state;
    salc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= salc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            salc_pkg::ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = salc_pkg::ST_IDLE;
                end
            end
            salc_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = salc_pkg::ST_LOOKUP;
                end
            end
            salc_pkg::ST_LOOKUP: begin
                // hold the set row until the result slot can take the result
                o_cmd.update = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = salc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = salc_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/core/salc_dp.sv
// ----------------------------------------------------------------------------
// salc_dp: cache lookup datapath
// address split, set row memory, way compare, lru pick, counters, result register
// ----------------------------------------------------------------------------
module salc_dp #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  salc_pkg::t_cfg                  i_cfg,
    input  salc_pkg::t_cmd                  i_cmd,
    output salc_pkg::t_sts                  o_sts,
    input  logic [salc_pkg::OP_W-1:0]       i_operation,
    input  logic [salc_pkg::ADDR_W-1:0]     i_address,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [salc_pkg::OUTC_W-1:0]     o_outcome,
    output logic                            o_extra_hit,
    output logic [salc_pkg::CNT_W-1:0]      o_hit_total,
    output logic [salc_pkg::CNT_W-1:0]      o_miss_total,
    output logic [salc_pkg::CNT_W-1:0]      o_eviction_total
);

    localparam int TAG_W    = salc_pkg::TAG_W;
    localparam int STAMP_W  = salc_pkg::STAMP_W;
    localparam int CNT_W    = salc_pkg::CNT_W;
    localparam int ADDR_W   = salc_pkg::ADDR_W;
    localparam int SBITS_W  = salc_pkg::SBITS_W;
    localparam int ROW_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int SA_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int EW_W     = ($clog2(MAX_WAYS + 1) > salc_pkg::WAYS_W) ?
                              $clog2(MAX_WAYS + 1) : salc_pkg::WAYS_W;
    localparam int NL       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
    localparam int NP       = 1 << NL;
    localparam int TAG_BASE   = MAX_WAYS;
    localparam int STAMP_BASE = MAX_WAYS * (1 + TAG_W);
    localparam int ROW_W      = MAX_WAYS * (1 + TAG_W + STAMP_W);

    // ---- address split at accept ----
    logic [SBITS_W-1:0] s_eff;
    logic [6:0]         shamt;
    logic [ADDR_W-1:0]  set_full;
    logic [SA_W-1:0]    set_idx;
    logic [TAG_W-1:0]   tag_in;

    always_comb begin
        if ({1'b0, i_cfg.row_bits} > 5'(ROW_BITS_MAX)) begin
            s_eff = SBITS_W'(ROW_BITS_MAX);
        end else begin
            s_eff = i_cfg.row_bits;
        end
        shamt    = {1'b0, i_cfg.offset_bits} + {3'b000, s_eff};
        set_full = (i_address >> i_cfg.offset_bits) & ~({ADDR_W{1'b1}} << s_eff);
        set_idx  = set_full[SA_W-1:0];
        tag_in   = shamt[6] ? '0 : (i_address >> shamt[5:0]);
    end

    logic [TAG_W-1:0]            r_tag;
    logic [SA_W-1:0]             r_set;
    logic [salc_pkg::OP_W-1:0]   r_op;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tag <= tag_in;
            r_set <= set_idx;
            r_op  <= i_operation;
        end
    end

    // ---- clearing pass counter ----
    logic [SA_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_addr <= r_clr_addr + SA_W'(1);
        end
    end

    // ---- set row memory ----
    logic             ram_we;
    logic [SA_W-1:0]  ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] row_q;
    logic [ROW_W-1:0] n_row;
    logic             is_fetch;

    assign is_fetch  = (r_op == salc_pkg::OP_IFETCH);
    assign ram_we    = i_cmd.clear_wr | (i_cmd.update & ~is_fetch);
    assign ram_waddr = i_cmd.clear_wr ? r_clr_addr : r_set;
    assign ram_wdata = i_cmd.clear_wr ? '0 : n_row;

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (set_idx),
        .o_rd_data (row_q)
    );

    // ---- way compare ----
    logic [EW_W-1:0]    e_eff;
    logic [MAX_WAYS-1:0] cand;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] empty_vec;
    logic [STAMP_W-1:0]  way_stamp [0:MAX_WAYS-1];
    logic [WAY_W-1:0]    hit_idx;
    logic [WAY_W-1:0]    empty_idx;

    always_comb begin
        if (EW_W'(i_cfg.ways) == '0) begin
            e_eff = EW_W'(1);
        end else if (EW_W'(i_cfg.ways) > EW_W'(MAX_WAYS)) begin
            e_eff = EW_W'(MAX_WAYS);
        end else begin
            e_eff = EW_W'(i_cfg.ways);
        end
        hit_idx   = '0;
        empty_idx = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            cand[w]      = (EW_W'(w) < e_eff);
            way_stamp[w] = row_q[STAMP_BASE + w*STAMP_W +: STAMP_W];
            hit_vec[w]   = cand[w] & row_q[w] & (row_q[TAG_BASE + w*TAG_W +: TAG_W] == r_tag);
            empty_vec[w] = cand[w] & ~row_q[w];
        end
        // lowest matching / lowest empty way wins
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_idx = WAY_W'(w);
            end
            if (empty_vec[w]) begin
                empty_idx = WAY_W'(w);
            end
        end
    end

    // ---- least stamp tree, ties to the lower way ----
    logic [STAMP_W-1:0] lv_stamp [0:NL][0:NP-1];
    logic [WAY_W-1:0]   lv_idx   [0:NL][0:NP-1];
    logic               lv_ok    [0:NL][0:NP-1];
    logic [WAY_W-1:0]   lru_idx;

    always_comb begin
        logic take_r;
        take_r = 1'b0;
        for (int l = 0; l <= NL; l++) begin
            for (int n = 0; n < NP; n++) begin
                lv_stamp[l][n] = '0;
                lv_idx[l][n]   = '0;
                lv_ok[l][n]    = 1'b0;
            end
        end
        for (int n = 0; n < NP; n++) begin
            lv_idx[0][n] = WAY_W'(n);
            if (n < MAX_WAYS) begin
                lv_stamp[0][n] = way_stamp[n];
                lv_ok[0][n]    = cand[n];
            end
        end
        for (int l = 0; l < NL; l++) begin
            for (int n = 0; n < NP / 2; n++) begin
                if (n < (NP >> (l + 1))) begin
                    take_r = lv_ok[l][2*n+1] &&
                             (!lv_ok[l][2*n] || (lv_stamp[l][2*n+1] < lv_stamp[l][2*n]));
                    lv_ok[l+1][n]    = lv_ok[l][2*n] | lv_ok[l][2*n+1];
                    lv_stamp[l+1][n] = take_r ? lv_stamp[l][2*n+1] : lv_stamp[l][2*n];
                    lv_idx[l+1][n]   = take_r ? lv_idx[l][2*n+1]   : lv_idx[l][2*n];
                end
            end
        end
        lru_idx = lv_idx[NL][0];
    end

    // ---- victim and row update ----
    logic                        any_hit;
    logic                        any_empty;
    logic [WAY_W-1:0]            victim;
    logic [salc_pkg::OUTC_W-1:0] n_outcome;
    logic [STAMP_W-1:0]          r_clock;

    assign any_hit   = |hit_vec;
    assign any_empty = |empty_vec;

    always_comb begin
        if (any_hit) begin
            victim = hit_idx;
        end else if (any_empty) begin
            victim = empty_idx;
        end else begin
            victim = lru_idx;
        end
        if (is_fetch) begin
            n_outcome = salc_pkg::OUT_NONE;
        end else if (any_hit) begin
            n_outcome = salc_pkg::OUT_HIT;
        end else if (any_empty) begin
            n_outcome = salc_pkg::OUT_MISS;
        end else begin
            n_outcome = salc_pkg::OUT_EVICT;
        end
        n_row = row_q;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == victim) begin
                n_row[w]                                = 1'b1;
                n_row[TAG_BASE + w*TAG_W +: TAG_W]       = r_tag;
                n_row[STAMP_BASE + w*STAMP_W +: STAMP_W] = r_clock;
            end
        end
    end

    // ---- counters ----
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] r_evicts;
    logic [CNT_W+1:0] hit_sum;
    logic [CNT_W-1:0] n_hits;
    logic             hit_now;
    logic             mod_now;
    logic             miss_now;
    logic             evict_now;

    always_comb begin
        hit_now   = (n_outcome == salc_pkg::OUT_HIT);
        mod_now   = (r_op == salc_pkg::OP_MODIFY);
        miss_now  = (n_outcome == salc_pkg::OUT_MISS) || (n_outcome == salc_pkg::OUT_EVICT);
        evict_now = (n_outcome == salc_pkg::OUT_EVICT);
        hit_sum   = {2'b00, r_hits} + {{(CNT_W+1){1'b0}}, hit_now}
                  + {{(CNT_W+1){1'b0}}, mod_now};
        n_hits    = (|hit_sum[CNT_W+1:CNT_W]) ? {CNT_W{1'b1}} : hit_sum[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && (r_clock != {STAMP_W{1'b1}})) begin
                r_clock <= r_clock + STAMP_W'(1);
            end
            if (i_cmd.update) begin
                r_hits <= n_hits;
                if (miss_now && (r_misses != {CNT_W{1'b1}})) begin
                    r_misses <= r_misses + CNT_W'(1);
                end
                if (evict_now && (r_evicts != {CNT_W{1'b1}})) begin
                    r_evicts <= r_evicts + CNT_W'(1);
                end
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // result payload; counters only move when the slot is free, so they drive totals
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_outcome   <= n_outcome;
            o_extra_hit <= mod_now;
        end
    end

    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evicts;

    assign o_sts.clear_last = (r_clr_addr == SA_W'(MAX_SETS - 1));
    assign o_sts.out_free   = ~o_out_valid | i_out_ready;

endmodule

// File: test/tb_set_assoc_lru_cache_sim.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_sim: testbench of the lru cache simulator
// a clocked driver feeds access items from a queue with random gaps while the
// result side stalls at random; a behavioral lru model predicts every result
// item, which is compared field by field in arrival order, across several
// cache geometries written through the configuration port between phases
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_sim;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SETS     = 256;
    localparam int MAX_WAYS     = 8;
    localparam int DRAIN_CYCLES = 4;

    // load and store codes are not in the package
    localparam logic [salc_pkg::OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [salc_pkg::OP_W-1:0] OP_STORE = 2'd1;

    typedef struct packed {
        logic [salc_pkg::OP_W-1:0]   operation;
        logic [salc_pkg::ADDR_W-1:0] address;
    } t_access;

    typedef struct packed {
        logic [salc_pkg::OUTC_W-1:0] outcome;
        logic                        extra_hit;
        logic [salc_pkg::CNT_W-1:0]  hit_total;
        logic [salc_pkg::CNT_W-1:0]  miss_total;
        logic [salc_pkg::CNT_W-1:0]  eviction_total;
    } t_tally;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_wr_en;
    logic [salc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [salc_pkg::CFG_DAT_W-1:0] cfg_wdata;

    salc_req_if req_ch ();
    salc_rsp_if rsp_ch ();

    set_assoc_lru_cache_sim #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // lru model state: its own copy of the lines, clock, totals and geometry
    // ------------------------------------------------------------------------
    bit                           way_valid [MAX_SETS*MAX_WAYS];
    logic [salc_pkg::TAG_W-1:0]   way_tag   [MAX_SETS*MAX_WAYS];
    logic [salc_pkg::STAMP_W-1:0] way_stamp [MAX_SETS*MAX_WAYS];
    logic [salc_pkg::STAMP_W-1:0] use_clock;
    logic [salc_pkg::CNT_W-1:0]   hit_count;
    logic [salc_pkg::CNT_W-1:0]   miss_count;
    logic [salc_pkg::CNT_W-1:0]   evict_count;
    logic [salc_pkg::SBITS_W-1:0] cfg_sbits;
    logic [salc_pkg::WAYS_W-1:0]  cfg_ways;
    logic [salc_pkg::OFFS_W-1:0]  cfg_offs;

    // items waiting for the driver, results waiting for the block
    t_access pending_accesses [$];
    t_tally  awaited_tallies  [$];

    int unsigned queued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned checked_cnt  = 0;
    int unsigned errors       = 0;

    logic        req_fired = 1'b0;
    int unsigned req_gap   = 0;
    int unsigned req_calm  = 0;
    int unsigned rsp_stall = 0;
    int unsigned rsp_calm  = 0;

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // set bits beyond what MAX_SETS can hold are dropped
    function automatic int unsigned eff_row_bits();
        int unsigned s;
        s = 32'(cfg_sbits);
        while (s > 0 && (1 << s) > MAX_SETS)
            s--;
        return s;
    endfunction

    // one access through the cache model, returns the result item it causes
    function automatic t_tally lru_access(t_access acc);
        int unsigned                 s;
        int unsigned                 e;
        int unsigned                 b;
        int unsigned                 sh;
        int unsigned                 base;
        int unsigned                 slot;
        logic [salc_pkg::ADDR_W-1:0] set_idx;
        logic [salc_pkg::TAG_W-1:0]  tag;
        bit                          found;
        t_tally                      t;
        t.outcome   = salc_pkg::OUT_NONE;
        t.extra_hit = 1'b0;
        // the clock moves on every access, instruction fetches too
        use_clock = sat_inc(use_clock);
        if (acc.operation != salc_pkg::OP_IFETCH) begin
            s     = eff_row_bits();
            e     = (cfg_ways < 1) ? 1 : (cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways;
            b     = 32'(cfg_offs);
            sh    = b + s;
            set_idx = (acc.address >> b) & ((64'd1 << s) - 64'd1);
            // tag is zero once offset and set cover the whole address
            tag   = (sh >= salc_pkg::ADDR_W) ? '0 : acc.address >> sh;
            base  = 32'(set_idx * MAX_WAYS);
            found = 1'b0;
            slot  = 0;
            // first valid matching way hits
            for (int w = 0; w < e && !found; w++) begin
                if (way_valid[base+w] && way_tag[base+w] == tag) begin
                    slot      = w;
                    found     = 1'b1;
                    t.outcome = salc_pkg::OUT_HIT;
                    hit_count = sat_inc(hit_count);
                end
            end
            // else the lowest empty way
            for (int w = 0; w < e && !found; w++) begin
                if (!way_valid[base+w]) begin
                    slot      = w;
                    found     = 1'b1;
                    t.outcome = salc_pkg::OUT_MISS;
                    miss_count = sat_inc(miss_count);
                end
            end
            // else the least stamp, ties to the lowest way
            if (!found) begin
                slot = 0;
                for (int w = 1; w < e; w++) begin
                    if (way_stamp[base+w] < way_stamp[base+slot])
                        slot = w;
                end
                t.outcome   = salc_pkg::OUT_EVICT;
                miss_count  = sat_inc(miss_count);
                evict_count = sat_inc(evict_count);
            end
            way_valid[base+slot] = 1'b1;
            way_tag[base+slot]   = tag;
            way_stamp[base+slot] = use_clock;
        end
        // modify adds the hit of its store half
        if (acc.operation == salc_pkg::OP_MODIFY) begin
            hit_count   = sat_inc(hit_count);
            t.extra_hit = 1'b1;
        end
        t.hit_total      = hit_count;
        t.miss_total     = miss_count;
        t.eviction_total = evict_count;
        return t;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] wanted);
        $display("mismatch at result %0d: %s got %0h want %0h",
                 checked_cnt, field, seen, wanted);
        errors++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // request driver: changes at the falling edge, holds until taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_req
        t_access nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_fired) begin
            if (req_gap > 0) begin
                req_ch.valid <= 1'b0;
                req_gap--;
            end else if (pending_accesses.size() > 0) begin
                nxt = pending_accesses.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.operation <= nxt.operation;
                req_ch.address   <= nxt.address;
                // gap that follows this item, with stretches of back to back items
                if (req_calm > 0) begin
                    req_calm--;
                end else begin
                    req_gap = pick_gap();
                    if ($urandom_range(0, 39) == 0)
                        req_calm = $urandom_range(20, 60);
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result side back-pressure, also with calm stretches
    always @(negedge i_clk) begin : drive_rsp
        if (rsp_stall > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall--;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_calm > 0) begin
                rsp_calm--;
            end else if ($urandom_range(0, 3) == 0) begin
                rsp_stall = pick_gap();
                if ($urandom_range(0, 19) == 0)
                    rsp_calm = $urandom_range(20, 60);
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: at the rising edge, predict accepted items and check results
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_access acc;
        t_tally  want;
        req_fired <= req_ch.valid && req_ch.ready;
        if (i_rst_n) begin
            // result first, so an item taken at this edge is not matched to it
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (awaited_tallies.size() == 0) begin
                    report_mismatch("result with nothing awaited", 64'(rsp_ch.outcome), '0);
                end else begin
                    want = awaited_tallies.pop_front();
                    if (rsp_ch.outcome !== want.outcome)
                        report_mismatch("outcome", 64'(rsp_ch.outcome), 64'(want.outcome));
                    if (rsp_ch.extra_hit !== want.extra_hit)
                        report_mismatch("extra_hit", 64'(rsp_ch.extra_hit),
                                        64'(want.extra_hit));
                    if (rsp_ch.hit_total !== want.hit_total)
                        report_mismatch("hit_total", 64'(rsp_ch.hit_total),
                                        64'(want.hit_total));
                    if (rsp_ch.miss_total !== want.miss_total)
                        report_mismatch("miss_total", 64'(rsp_ch.miss_total),
                                        64'(want.miss_total));
                    if (rsp_ch.eviction_total !== want.eviction_total)
                        report_mismatch("eviction_total", 64'(rsp_ch.eviction_total),
                                        64'(want.eviction_total));
                end
                checked_cnt++;
            end
            if (req_ch.valid && req_ch.ready) begin
                acc.operation = req_ch.operation;
                acc.address   = req_ch.address;
                awaited_tallies.push_back(lru_access(acc));
                accepted_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_access(logic [salc_pkg::OP_W-1:0] op,
                                logic [salc_pkg::ADDR_W-1:0] addr);
        t_access a;
        a.operation = op;
        a.address   = addr;
        pending_accesses.push_back(a);
        queued_cnt++;
    endtask

    // every item taken and every result back, then a quiet drain
    task automatic wait_idle();
        @(negedge i_clk);
        while (accepted_cnt != queued_cnt || awaited_tallies.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [salc_pkg::CFG_IDX_W-1:0] idx,
                             logic [salc_pkg::CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            salc_pkg::CFG_ROW_BITS:    cfg_sbits = val[salc_pkg::SBITS_W-1:0];
            salc_pkg::CFG_WAYS:        cfg_ways  = val[salc_pkg::WAYS_W-1:0];
            salc_pkg::CFG_OFFSET_BITS: cfg_offs  = val[salc_pkg::OFFS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned sbits, int unsigned ways, int unsigned offs);
        write_reg(salc_pkg::CFG_ROW_BITS, salc_pkg::CFG_DAT_W'(sbits));
        write_reg(salc_pkg::CFG_WAYS, salc_pkg::CFG_DAT_W'(ways));
        write_reg(salc_pkg::CFG_OFFSET_BITS, salc_pkg::CFG_DAT_W'(offs));
        @(posedge i_clk);
    endtask

    // accesses built from a small tag pool and a few sets so that hits and
    // evictions are common, with some fully random addresses mixed in
    task automatic random_accesses(int unsigned count, int unsigned pool_n,
                                   int unsigned set_span);
        logic [salc_pkg::TAG_W-1:0]  pool [16];
        int unsigned                 s;
        int unsigned                 b;
        int unsigned                 r;
        logic [salc_pkg::ADDR_W-1:0] addr;
        logic [salc_pkg::ADDR_W-1:0] row_mask;
        logic [salc_pkg::OP_W-1:0]   op;
        s        = eff_row_bits();
        b        = 32'(cfg_offs);
        row_mask = (64'd1 << s) - 64'd1;
        for (int k = 0; k < 16; k++)
            pool[k] = {$urandom, $urandom};
        for (int unsigned i = 0; i < count; i++) begin
            r  = $urandom_range(0, 9);
            op = (r < 4) ? OP_LOAD : (r < 7) ? OP_STORE :
                 (r < 9) ? salc_pkg::OP_MODIFY : salc_pkg::OP_IFETCH;
            if ($urandom_range(0, 99) < 15)
                addr = {$urandom, $urandom};
            else
                addr = (pool[$urandom_range(0, pool_n - 1)] << (b + s))
                     | ((64'($urandom_range(0, set_span)) & row_mask) << b)
                     | ({$urandom, $urandom} & ((64'd1 << b) - 64'd1));
            queue_access(op, addr);
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = salc_pkg::CFG_ROW_BITS;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_LOAD;
        req_ch.address   = '0;
        rsp_ch.ready     = 1'b0;

        // model reset: lines invalid, clock and totals zero, geometry default
        for (int k = 0; k < MAX_SETS*MAX_WAYS; k++)
            way_valid[k] = 1'b0;
        use_clock   = '0;
        hit_count   = '0;
        miss_count  = '0;
        evict_count = '0;
        cfg_sbits   = salc_pkg::ROW_BITS_RST;
        cfg_ways    = salc_pkg::WAYS_RST;
        cfg_offs    = salc_pkg::OFFSET_BITS_RST;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default geometry, direct mapped: miss, hit in block, eviction,
        // modify on hit and on eviction, instruction fetch, address extremes
        queue_access(OP_LOAD,             64'h0);
        queue_access(OP_LOAD,             64'h0F);
        queue_access(OP_STORE,            64'h100);
        queue_access(salc_pkg::OP_MODIFY, 64'h100);
        queue_access(salc_pkg::OP_MODIFY, 64'h200);
        queue_access(salc_pkg::OP_IFETCH, 64'h200);
        queue_access(OP_LOAD,             64'hFFFF_FFFF_FFFF_FFFF);
        queue_access(OP_STORE,            64'hFFFF_FFFF_FFFF_FFF0);
        queue_access(salc_pkg::OP_IFETCH, 64'h0);
        random_accesses(60, 3, 3);
        wait_idle();

        // one set of two ways: lru order decides which line goes
        configure(0, 2, 0);
        queue_access(OP_LOAD,             64'd1);
        queue_access(OP_LOAD,             64'd2);
        queue_access(OP_LOAD,             64'd1);
        queue_access(OP_STORE,            64'd3);
        queue_access(OP_LOAD,             64'd2);
        queue_access(salc_pkg::OP_MODIFY, 64'd3);
        random_accesses(50, 4, 0);
        wait_idle();

        // too many set bits, full ways, offset and set cover the address: tag always zero
        configure(15, 8, 56);
        queue_access(OP_LOAD, 64'hFF00_0000_0000_0000);
        queue_access(OP_LOAD, 64'hFF12_3456_789A_BCDE);
        random_accesses(50, 10, 3);
        wait_idle();

        // ways above the maximum, widest offset field value
        configure(8, 15, 63);
        queue_access(OP_LOAD,  64'h8000_0000_0000_0001);
        queue_access(OP_STORE, 64'h7FFF_FFFF_FFFF_FFFF);
        random_accesses(40, 4, 1);
        wait_idle();

        // zero ways acts as one
        configure(2, 0, 0);
        random_accesses(60, 3, 3);
        wait_idle();

        // four ways, with a full drain in the middle of the stream
        configure(3, 4, 6);
        random_accesses(60, 6, 3);
        wait_idle();
        random_accesses(60, 6, 3);
        wait_idle();

        configure(1, 8, 12);
        random_accesses(80, 12, 1);
        wait_idle();

        configure(8, 3, 0);
        random_accesses(80, 5, 2);
        wait_idle();

        if (errors == 0) begin
            $display("PASS set_assoc_lru_cache_sim");
        end else begin
            $display("FAIL set_assoc_lru_cache_sim");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("FAIL set_assoc_lru_cache_sim");
        $finish;
    end

endmodule
